FILE: hw/rtl/sawtc_pkg.sv
// ----------------------------------------------------------------------------
// sawtc_pkg
// Shared types and constants of the set-associative write-through cache.
// ----------------------------------------------------------------------------
package sawtc_pkg;

  localparam int SETS          = 128;
  localparam int WAYS          = 8;
  localparam int LINE_BYTES    = 64;
  localparam int MEM_ADDR_BITS = 18;

  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MEM_LINE_W = MEM_ADDR_BITS - OFF_W;
  localparam int MEM_LINES  = 1 << MEM_LINE_W;
  localparam int TAG_W      = MEM_LINE_W - SET_W;
  localparam int LINE_W     = LINE_BYTES * 8;
  localparam int TENTRY_W   = TAG_W + 1;
  localparam int TWORD_W    = WAYS * TENTRY_W;
  localparam int CIDX_W     = SET_W + WAY_W;
  localparam int CLINES     = SETS << WAY_W;

  localparam logic [15:0] LFSR_RESET = 16'hACE1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [MEM_ADDR_BITS-1:0] address;
    logic [2:0]               length;
    logic [31:0]              write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic        filled;
    logic [2:0]  fill_way;
  } rsp_t;

endpackage

FILE: hw/rtl/sawtc_ram.sv
// ----------------------------------------------------------------------------
// sawtc_ram
// Generic simple dual-port RAM: one masked write port, one registered read.
// ----------------------------------------------------------------------------
module sawtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= (mem_q[waddr_i] & ~wmask_i) | (wdata_i & wmask_i);
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/set_assoc_write_through_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache
// 8-way, 128-set write-through cache of 64-byte lines over an internal
// 256 KiB backing memory.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass (one backing memory line per
// cycle) and accepts no transaction until it is done. One transaction is
// worked at a time. Every step waits on the registered read of the tag RAM,
// the line-wide backing RAM or the cache data RAM: a write passes LOOK1,
// a read hit LOOK1 and DATA1, a read miss LOOK1; a line-crossing access adds
// LOOK2, DATA2 or MEM2 (not a read hitting first and missing second). A new
// transaction is taken once the output register is free or being taken.
module set_assoc_write_through_cache (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sawtc_pkg::req_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sawtc_pkg::rsp_t     out_data_o
);
  import sawtc_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LOOK1 = 7'b0000100,
    ST_DATA1 = 7'b0001000,
    ST_DATA2 = 7'b0010000,
    ST_MEM2  = 7'b0100000,
    ST_LOOK2 = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [MEM_LINE_W-1:0] clr_q, clr_d;
  logic [15:0] lfsr_q, lfsr_d;
  logic cmd_q;
  logic [MEM_ADDR_BITS-1:0] addr_q;
  logic [2:0] len_q;
  logic [31:0] wdata_q;
  logic [31:0] rd_q, rd_d;
  logic hit_q, hit_d;
  logic [2:0] fway_q, fway_d;
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  // memory ports
  logic mem_we, mem_re, tag_we, tag_re, dat_we, dat_re;
  logic [MEM_LINE_W-1:0] mem_waddr, mem_raddr;
  logic [LINE_W-1:0] mem_wdata, mem_wmask, mem_rdata;
  logic [SET_W-1:0] tag_waddr, tag_raddr;
  logic [TWORD_W-1:0] tag_wdata, tag_rdata;
  logic [CIDX_W-1:0] dat_waddr, dat_raddr;
  logic [LINE_W-1:0] dat_wdata, dat_wmask, dat_rdata;

  sawtc_ram #(.WIDTH(LINE_W), .DEPTH(MEM_LINES)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .wmask_i(mem_wmask), .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );
  sawtc_ram #(.WIDTH(TWORD_W), .DEPTH(SETS)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(tag_waddr), .wdata_i(tag_wdata),
    .wmask_i({TWORD_W{1'b1}}), .re_i(tag_re), .raddr_i(tag_raddr),
    .rdata_o(tag_rdata)
  );
  sawtc_ram #(.WIDTH(LINE_W), .DEPTH(CLINES)) u_dat (
    .clk_i, .we_i(dat_we), .waddr_i(dat_waddr), .wdata_i(dat_wdata),
    .wmask_i(dat_wmask), .re_i(dat_re), .raddr_i(dat_raddr), .rdata_o(dat_rdata)
  );

  function automatic logic [31:0] expand4(input logic [3:0] m);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = {8{m[i]}};
    end
    return r;
  endfunction

  // request decode
  logic accept;
  logic [2:0] len_in;
  logic [OFF_W-1:0] off;
  logic [OFF_W:0] room;
  logic [2:0] flen;
  logic split;
  logic [MEM_LINE_W-1:0] line1, line2;
  logic [SET_W-1:0] set1, set2, look_set;
  logic [TAG_W-1:0] tag1, tag2, look_tag;
  logic [3:0] m1, m2, mall;
  logic [31:0] bm1, bm2;
  logic [LINE_W-1:0] wline1, wline2, wmask1, wmask2;

  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_data_i.length == 3'd0) begin
      len_in = 3'd1;
    end else if (in_data_i.length > 3'd4) begin
      len_in = 3'd4;
    end else begin
      len_in = in_data_i.length;
    end
  end

  assign off   = addr_q[OFF_W-1:0];
  assign room  = (OFF_W+1)'(LINE_BYTES) - {1'b0, off};
  assign split = (OFF_W+1)'(len_q) > room;
  assign flen  = split ? room[2:0] : len_q;
  assign line1 = addr_q[MEM_ADDR_BITS-1:OFF_W];
  assign line2 = line1 + 1'b1;
  assign set1  = line1[SET_W-1:0];
  assign set2  = line2[SET_W-1:0];
  assign tag1  = line1[MEM_LINE_W-1:SET_W];
  assign tag2  = line2[MEM_LINE_W-1:SET_W];
  assign look_set = (state_q == ST_LOOK1) ? set1 : set2;
  assign look_tag = (state_q == ST_LOOK1) ? tag1 : tag2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mall[i] = 3'(i) < len_q;
      m1[i]   = 3'(i) < flen;
    end
  end
  assign m2  = mall & ~m1;
  assign bm1 = expand4(m1);
  assign bm2 = expand4(m2);

  assign wline1 = LINE_W'(wdata_q) << {off, 3'b000};
  assign wmask1 = LINE_W'(bm1) << {off, 3'b000};
  assign wline2 = LINE_W'(wdata_q >> {flen, 3'b000});
  assign wmask2 = LINE_W'(bm2 >> {flen, 3'b000});

  // byte extraction from a line for the first and the second part
  logic [31:0] mem_p1, dat_p1, mem_p2, dat_p2;
  assign mem_p1 = 32'(mem_rdata >> {off, 3'b000}) & bm1;
  assign dat_p1 = 32'(dat_rdata >> {off, 3'b000}) & bm1;
  assign mem_p2 = (mem_rdata[31:0] << {flen, 3'b000}) & bm2;
  assign dat_p2 = (dat_rdata[31:0] << {flen, 3'b000}) & bm2;

  // tag lookup and victim choice on the tag word just read
  logic hit_any, inv_any, fb;
  logic [WAY_W-1:0] hit_way, inv_way, victim;
  logic [15:0] lfsr_next;
  logic [TWORD_W-1:0] tw_new;

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!tag_rdata[w*TENTRY_W + TAG_W]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tag_rdata[w*TENTRY_W + TAG_W] &&
          tag_rdata[w*TENTRY_W +: TAG_W] == look_tag) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign fb        = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_next = {fb, lfsr_q[15:1]};
  assign victim    = inv_any ? inv_way : WAY_W'(lfsr_next % WAYS);

  always_comb begin
    tw_new = tag_rdata;
    tw_new[victim*TENTRY_W +: TENTRY_W] = {1'b1, look_tag};
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lfsr_d      = lfsr_q;
    rd_d        = rd_q;
    hit_d       = hit_q;
    fway_d      = fway_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we = 1'b0; mem_re = 1'b0; tag_we = 1'b0; tag_re = 1'b0;
    dat_we = 1'b0; dat_re = 1'b0;
    mem_waddr = line1;
    mem_raddr = line2;
    mem_wdata = wline1;
    mem_wmask = wmask1;
    tag_waddr = look_set;
    tag_raddr = set2;
    tag_wdata = tw_new;
    dat_waddr = {look_set, victim};
    dat_raddr = {look_set, hit_way};
    dat_wdata = mem_rdata;
    dat_wmask = '1;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        mem_wmask = '1;
        tag_we    = 1'b1;
        tag_waddr = clr_q[SET_W-1:0];
        tag_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mem_re    = 1'b1;
          mem_raddr = in_data_i.address[MEM_ADDR_BITS-1:OFF_W];
          tag_re    = 1'b1;
          tag_raddr = in_data_i.address[OFF_W +: SET_W];
          state_d   = ST_LOOK1;
        end
      end
      ST_LOOK1: begin
        if (cmd_q == CMD_WRITE) begin
          mem_we    = 1'b1;
          dat_we    = hit_any;
          dat_waddr = {set1, hit_way};
          dat_wdata = wline1;
          dat_wmask = wmask1;
          hit_d     = hit_any;
          if (split) begin
            tag_re  = 1'b1;
            state_d = ST_LOOK2;
          end else begin
            out_valid_d = 1'b1;
            out_d       = '{read_data: '0, hit: hit_any, filled: 1'b0, fill_way: '0};
            state_d     = ST_IDLE;
          end
        end else if (hit_any) begin
          dat_re  = 1'b1;
          tag_re  = split;
          mem_re  = split;
          state_d = ST_DATA1;
        end else begin
          // read miss: bytes come from memory, the first line is filled
          dat_we = 1'b1;
          tag_we = 1'b1;
          if (!inv_any) begin
            lfsr_d = lfsr_next;
          end
          rd_d   = mem_p1;
          fway_d = 3'(victim);
          if (split) begin
            mem_re  = 1'b1;
            state_d = ST_MEM2;
          end else begin
            out_valid_d = 1'b1;
            out_d       = '{read_data: mem_p1, hit: 1'b0, filled: 1'b1,
                            fill_way: 3'(victim)};
            state_d     = ST_IDLE;
          end
        end
      end
      ST_DATA1: begin
        rd_d = dat_p1;
        if (!split) begin
          out_valid_d = 1'b1;
          out_d       = '{read_data: dat_p1, hit: 1'b1, filled: 1'b0, fill_way: '0};
          state_d     = ST_IDLE;
        end else if (hit_any) begin
          dat_re  = 1'b1;
          state_d = ST_DATA2;
        end else begin
          dat_we = 1'b1;
          tag_we = 1'b1;
          if (!inv_any) begin
            lfsr_d = lfsr_next;
          end
          out_valid_d = 1'b1;
          out_d       = '{read_data: dat_p1 | mem_p2, hit: 1'b0, filled: 1'b1,
                          fill_way: 3'(victim)};
          state_d     = ST_IDLE;
        end
      end
      ST_DATA2: begin
        out_valid_d = 1'b1;
        out_d       = '{read_data: rd_q | dat_p2, hit: 1'b1, filled: 1'b0, fill_way: '0};
        state_d     = ST_IDLE;
      end
      ST_MEM2: begin
        out_valid_d = 1'b1;
        out_d       = '{read_data: rd_q | mem_p2, hit: 1'b0, filled: 1'b1,
                        fill_way: fway_q};
        state_d     = ST_IDLE;
      end
      ST_LOOK2: begin
        mem_we    = 1'b1;
        mem_waddr = line2;
        mem_wdata = wline2;
        mem_wmask = wmask2;
        dat_we    = hit_any;
        dat_waddr = {set2, hit_way};
        dat_wdata = wline2;
        dat_wmask = wmask2;
        out_valid_d = 1'b1;
        out_d       = '{read_data: '0, hit: hit_q && hit_any, filled: 1'b0,
                        fill_way: '0};
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lfsr_q      <= LFSR_RESET;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lfsr_q      <= lfsr_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_data_i.cmd;
      addr_q  <= in_data_i.address;
      len_q   <= len_in;
      wdata_q <= in_data_i.write_data;
    end
    rd_q   <= rd_d;
    fway_q <= fway_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start");
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != ST_IDLE && $past(state_q) != ST_CLEAR)
    else $error("result appeared without a transaction");
  a_fill_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.filled && out_q.hit))
    else $error("fill reported on a hit");
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o)
    else $error("transaction taken during clearing pass");

endmodule

FILE: verif/set_assoc_write_through_cache_test.sv
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache_test
// Self-checking bench: byte-level cache/memory predictor, random accesses with
// random gaps and stalls on both channels, directed corner accesses first.
// ----------------------------------------------------------------------------
module set_assoc_write_through_cache_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sawtc_pkg::*;

  localparam int MEM_SIZE    = 1 << MEM_ADDR_BITS;
  localparam int NUM_RANDOM  = 1200;
  localparam int CYCLE_LIMIT = 200000;

  // Predicted cache and memory contents; results are queued in order.
  class cache_scoreboard;
    logic [TAG_W-1:0] tags [SETS*WAYS];
    bit               vld  [SETS*WAYS];
    logic [7:0]       lines[SETS*WAYS*LINE_BYTES];
    logic [7:0]       mem  [MEM_SIZE];
    logic [15:0]      lfsr;
    rsp_t             pending[$];
    int               errors;
    int               checked;
    int               reads, writes, splits, fills, evictions;

    function new();
      foreach (tags[i]) begin
        tags[i] = '0;
        vld[i]  = 1'b0;
      end
      foreach (lines[i]) lines[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      lfsr = LFSR_RESET;
    endfunction

    function int lookup(int a);
      int s, t;
      s = (a / LINE_BYTES) % SETS;
      t = a / (LINE_BYTES * SETS);
      for (int w = 0; w < WAYS; w++)
        if (vld[s*WAYS+w] && tags[s*WAYS+w] == t) return w;
      return -1;
    endfunction

    function int line_base(int a, int w);
      return (((a / LINE_BYTES) % SETS) * WAYS + w) * LINE_BYTES;
    endfunction

    function int allocate(int a);
      int s, way, base, lb;
      logic b;
      s = (a / LINE_BYTES) % SETS;
      way = -1;
      for (int w = 0; w < WAYS; w++)
        if (!vld[s*WAYS+w]) way = w;
      if (way < 0) begin
        b = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
        lfsr = {b, lfsr[15:1]};
        way = lfsr % WAYS;
        evictions++;
      end
      base = a - (a % LINE_BYTES);
      lb = line_base(a, way);
      for (int k = 0; k < LINE_BYTES; k++)
        lines[lb+k] = mem[(base + k) % MEM_SIZE];
      vld[s*WAYS+way] = 1'b1;
      tags[s*WAYS+way] = TAG_W'(a / (LINE_BYTES * SETS));
      fills++;
      return way;
    endfunction

    function void note_request(req_t r);
      int a, len, off, l1, l2, a2, w1, w2;
      rsp_t e;
      a = int'(r.address);
      len = int'(r.length);
      if (len == 0) len = 1;
      if (len > 4) len = 4;
      off = a % LINE_BYTES;
      l1 = (len < LINE_BYTES - off) ? len : LINE_BYTES - off;
      l2 = len - l1;
      a2 = (a + l1) % MEM_SIZE;
      e = '0;
      e.hit = 1'b1;
      if (l2 > 0) splits++;
      if (r.cmd == CMD_WRITE) begin
        writes++;
        for (int i = 0; i < len; i++) mem[(a + i) % MEM_SIZE] = r.write_data[8*i +: 8];
        w1 = lookup(a);
        if (w1 >= 0) begin
          for (int i = 0; i < l1; i++)
            lines[line_base(a, w1) + off + i] = r.write_data[8*i +: 8];
        end else e.hit = 1'b0;
        if (l2 > 0) begin
          w2 = lookup(a2);
          if (w2 >= 0) begin
            for (int i = 0; i < l2; i++)
              lines[line_base(a2, w2) + i] = r.write_data[8*(l1+i) +: 8];
          end else e.hit = 1'b0;
        end
      end else begin
        reads++;
        w1 = lookup(a);
        if (w1 >= 0) begin
          for (int i = 0; i < l1; i++)
            e.read_data[8*i +: 8] = lines[line_base(a, w1) + off + i];
          if (l2 > 0) begin
            w2 = lookup(a2);
            if (w2 >= 0) begin
              for (int i = 0; i < l2; i++)
                e.read_data[8*(l1+i) +: 8] = lines[line_base(a2, w2) + i];
            end else begin
              for (int i = 0; i < l2; i++)
                e.read_data[8*(l1+i) +: 8] = mem[(a2 + i) % MEM_SIZE];
              e.hit = 1'b0;
              e.filled = 1'b1;
              e.fill_way = 3'(allocate(a2));
            end
          end
        end else begin
          for (int i = 0; i < len; i++)
            e.read_data[8*i +: 8] = mem[(a + i) % MEM_SIZE];
          e.hit = 1'b0;
          e.filled = 1'b1;
          e.fill_way = 3'(allocate(a));
        end
      end
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch #%0d: %s got %h expected %h", checked, what, got, want);
      errors++;
    endtask

    task check_response(rsp_t r);
      rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 32'(r), 32'h0);
        return;
      end
      e = pending.pop_front();
      if (r.read_data !== e.read_data) report("read_data", r.read_data, e.read_data);
      if (r.hit !== e.hit) report("hit", 32'(r.hit), 32'(e.hit));
      if (r.filled !== e.filled) report("filled", 32'(r.filled), 32'(e.filled));
      if (r.fill_way !== e.fill_way) report("fill_way", 32'(r.fill_way), 32'(e.fill_way));
      checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  cache_scoreboard sb = new();
  int  cycles = 0;
  int  hold_off = 0;
  bit  stall_random = 1'b1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  set_assoc_write_through_cache dut (.*);

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_response(out_data_o);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else if (stall_random) begin
        out_stall_i <= (pick_gap() > 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Valid stays up after the accepting edge; idle_cycles and drain drop it.
  task send_access(logic cmd, int addr, int len, logic [31:0] data);
    req_t r;
    r.cmd = cmd;
    r.address = MEM_ADDR_BITS'(addr);
    r.length = 3'(len);
    r.write_data = data;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task idle_cycles(int n);
    if (n > 0) in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Mostly reuse a small working set so that hits, evictions and splits occur.
  function int random_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ($urandom_range(0, 11) * SETS * LINE_BYTES + $urandom_range(0, 3)
                        * LINE_BYTES + $urandom_range(0, LINE_BYTES-1)) % MEM_SIZE;
    if (r < 55) return ($urandom_range(0, 15) * SETS * LINE_BYTES
                        + $urandom_range(0, 3) * LINE_BYTES + LINE_BYTES
                        - $urandom_range(1, 3)) % MEM_SIZE;
    if (r < 60) return MEM_SIZE - $urandom_range(1, 4);
    return $urandom_range(0, MEM_SIZE-1);
  endfunction

  initial begin
    int gap;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cold reads, writes, split hits/misses, top of memory wrap
    send_access(CMD_READ, 0, 4, 32'h0);
    send_access(CMD_WRITE, 0, 4, 32'hFFFF_FFFF);
    send_access(CMD_READ, 0, 4, 32'h0);
    send_access(CMD_WRITE, 62, 4, 32'hA5C3_5A3C);          // split, first line hits
    send_access(CMD_READ, 62, 4, 32'h0);                   // split, second misses
    send_access(CMD_READ, 62, 4, 32'h0);                   // split, both hit
    send_access(CMD_READ, 8192 + 61, 4, 32'h0);            // split, first misses
    send_access(CMD_WRITE, 8192 + 126, 3, 32'h1234_5678);  // split write, first misses
    send_access(CMD_READ, 8192 + 128, 1, 32'h0);
    send_access(CMD_WRITE, MEM_SIZE - 2, 4, 32'hDEAD_BEEF); // wraps to zero
    send_access(CMD_READ, MEM_SIZE - 1, 4, 32'h0);
    send_access(CMD_READ, 1, 0, 32'h0);                    // length 0 as 1
    send_access(CMD_READ, 1, 7, 32'h0);                    // 5..7 as 4
    send_access(CMD_WRITE, 5, 5, 32'h0BAD_F00D);
    send_access(CMD_READ, 4, 2, 32'h0);
    // fill one set past its ways to force LFSR victims
    for (int i = 0; i < 10; i++)
      send_access(CMD_READ, i * SETS * LINE_BYTES + 3 * LINE_BYTES, 1, 32'h0);

    // pressure: receiver holds off while sender keeps offering
    hold_off <= 300;
    for (int i = 0; i < 20; i++)
      send_access(1'($urandom_range(0, 1)), random_address(), $urandom_range(1, 4),
                  $urandom);
    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        drain();
        stall_random = 1'b0;
      end
      if (n == NUM_RANDOM / 2) stall_random = 1'b1;
      if ((n / 100) % 3 != 1) begin
        gap = pick_gap();
        idle_cycles(gap);
      end
      send_access(1'($urandom_range(0, 1)), random_address(), $urandom_range(0, 7),
                  $urandom);
    end
    drain();
    idle_cycles(20);
    $display("covered %0d reads, %0d writes, %0d line-crossing accesses",
             sb.reads, sb.writes, sb.splits);
    $display("%0d line fills, %0d random-victim evictions, %0d results checked",
             sb.fills, sb.evictions, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
